// ----- rtl/core/dnle_pkg.sv -----
`timescale 1ns / 1ps

package dnle_pkg;

    localparam int MAX_LABEL_DEF   = 63;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_name;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       root_follows;
        logic       overflow;
    } t_out_item;

    // classified item between front and back
    typedef struct packed {
        logic       is_flush;
        logic       root;
        logic [7:0] ch;
    } t_cmd;

endpackage

// ----- rtl/core/dnle_front.sv -----
`timescale 1ns / 1ps

module dnle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  dnle_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_q_push,
    output dnle_pkg::t_cmd    o_q_cmd
);

    logic           r_valid;
    logic           n_valid;
    dnle_pkg::t_cmd r_cmd;
    dnle_pkg::t_cmd n_cmd;

    // hold while the queue cannot take the classified item
    assign o_full   = r_valid & i_q_full;
    assign o_q_push = r_valid & ~i_q_full;
    assign o_q_cmd  = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (!o_full) begin
            n_valid      = i_push;
            n_cmd.is_flush = i_item.end_of_name | (i_item.char_in == dnle_pkg::DOT_CHAR);
            n_cmd.root   = i_item.end_of_name;
            n_cmd.ch     = i_item.char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// ----- rtl/core/dnle_queue.sv -----
`timescale 1ns / 1ps

module dnle_queue #(
    parameter int QUEUE_DEPTH = dnle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dnle_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dnle_pkg::t_cmd o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dnle_pkg::t_cmd   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/dnle_back.sv -----
`timescale 1ns / 1ps

module dnle_back #(
    parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  dnle_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output dnle_pkg::t_out_item o_result
);

    localparam int LEN_W  = $clog2(MAX_LABEL + 1);
    localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_BYTES
    } t_state;

    t_state              r_state,     n_state;
    logic [LEN_W-1:0]    r_len,       n_len;
    logic                r_ovf,       n_ovf;
    logic [LEN_W-1:0]    r_flen,      n_flen;
    logic                r_fovf,      n_fovf;
    logic                r_froot,     n_froot;
    logic [LEN_W-1:0]    r_idx,       n_idx;
    logic                r_out_valid, n_out_valid;
    dnle_pkg::t_out_item r_out,       n_out;

    logic [7:0]          r_mem [MAX_LABEL];
    logic [7:0]          r_rd_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic                out_ready;
    logic                fin;

    assign o_empty  = ~r_out_valid;
    assign o_result = r_out;
    assign out_ready = ~r_out_valid | i_pop;
    // read ahead at the next index so the data lines up with r_idx
    assign rd_addr  = n_idx[ADDR_W-1:0];
    assign fin      = (r_idx == r_flen - LEN_W'(1));

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_flen      = r_flen;
        n_fovf      = r_fovf;
        n_froot     = r_froot;
        n_idx       = r_idx;
        n_out_valid = r_out_valid & ~i_pop;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        mem_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (!i_cmd.is_flush) begin
                        if (r_len < LEN_W'(MAX_LABEL)) begin
                            mem_we = 1'b1;
                            n_len  = r_len + LEN_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_flen  = r_len;
                        n_fovf  = r_ovf;
                        n_froot = i_cmd.root;
                        n_len   = '0;
                        n_ovf   = 1'b0;
                        n_idx   = '0;
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.out_byte     = 8'(r_flen);
                    n_out.last         = (r_flen == '0);
                    n_out.root_follows = (r_flen == '0) & r_froot;
                    n_out.overflow     = r_fovf;
                    n_state            = (r_flen == '0) ? S_IDLE : S_BYTES;
                end
            end
            S_BYTES: begin
                if (out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.out_byte     = r_rd_data;
                    n_out.last         = fin;
                    n_out.root_follows = fin & r_froot;
                    n_out.overflow     = r_fovf;
                    if (fin) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + LEN_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_len[ADDR_W-1:0]] <= i_cmd.ch;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_flen  <= n_flen;
        r_fovf  <= n_fovf;
        r_froot <= n_froot;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

endmodule

// ----- rtl/core/dns_name_label_encoder.sv -----
`timescale 1ns / 1ps
// Channel   Handshake      Payload            Direction
// input     push / full    i_item (t_in_item)  in
// result    pop / empty    o_result (t_out_item) out
//
// A character item is taken from the queue in the back end's idle state; a flush is taken from
// the queue, then each emitted byte, length byte first, passes through the result register.
// Input items pass a front register and a QUEUE_DEPTH-deep queue, so full rises
// only once the queue is full behind a flush in progress.
// Synchronous active-low reset empties the queue, the result register and the label.
// A stalled pop holds the result register and the back end waits on it before its next byte.

module dns_name_label_encoder #(
    parameter int MAX_LABEL   = dnle_pkg::MAX_LABEL_DEF,
    parameter int QUEUE_DEPTH = dnle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  dnle_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output dnle_pkg::t_out_item o_result
);

    logic           q_full;
    logic           q_push;
    dnle_pkg::t_cmd q_in;
    logic           q_empty;
    logic           q_pop;
    dnle_pkg::t_cmd q_out;

    dnle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in)
    );

    dnle_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    dnle_back #(
        .MAX_LABEL (MAX_LABEL)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (~q_empty),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule
